### hdl/hlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlt_pkg
// Shared types and codes of the heartbeat liveness table.
// ----------------------------------------------------------------------------
package hlt_pkg;

  // Command codes carried by an input item
  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_ACK     = 3'd2,
    CMD_TICK    = 3'd3,
    CMD_MIGRATE = 3'd4
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXISTS    = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_e;

  localparam logic [15:0] LIMIT_RESET = 16'd3;
  localparam logic [15:0] MISSED_MAX  = 16'hFFFF;

  // One table entry, as held by a cell
  typedef struct packed {
    logic [31:0] id;
    logic [15:0] missed;
    logic        alive;
  } entry_t;

  // One result item
  typedef struct packed {
    status_e     status;
    logic        entry_valid;
    logic [31:0] entry_node;
    logic        entry_alive;
    logic [15:0] entry_missed;
    logic [3:0]  entry_index;
    logic        is_last;
    logic [63:0] beats_total;
    logic [63:0] migrations_total;
  } res_t;

endpackage

### hdl/hlt_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlt_cmd_if
// Command channel: one command and node id per item.
// ----------------------------------------------------------------------------
interface hlt_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] node_id;

  modport source (output valid, cmd, node_id, input ready);
  modport sink   (input valid, cmd, node_id, output ready);
endinterface

### hdl/hlt_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlt_res_if
// Result channel: one table report per item.
// ----------------------------------------------------------------------------
interface hlt_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        entry_valid;
  logic [31:0] entry_node;
  logic        entry_alive;
  logic [15:0] entry_missed;
  logic [3:0]  entry_index;
  logic        is_last;
  logic [63:0] beats_total;
  logic [63:0] migrations_total;

  modport source (output valid, status, entry_valid, entry_node, entry_alive,
                  entry_missed, entry_index, is_last, beats_total,
                  migrations_total, input ready);
  modport sink   (input valid, status, entry_valid, entry_node, entry_alive,
                  entry_missed, entry_index, is_last, beats_total,
                  migrations_total, output ready);
endinterface

### hdl/hlt_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlt_cfg_if
// Configuration write channel for the missed-beat limit.
// ----------------------------------------------------------------------------
interface hlt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] missed_limit;

  modport source (output valid, missed_limit, input ready);
  modport sink   (input valid, missed_limit, output ready);
endinterface

### hdl/hlt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlt_cell
// One table slot: takes its neighbor's entry on a shift or a new entry on a load.
// ----------------------------------------------------------------------------
module hlt_cell (
  input  logic            clk_i,
  input  logic            shift_en_i,
  input  logic            load_en_i,
  input  hlt_pkg::entry_t nbr_i,
  input  hlt_pkg::entry_t load_i,
  output hlt_pkg::entry_t entry_o
);

  hlt_pkg::entry_t entry_q;

  // Load wins over shift; hold otherwise
  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      entry_q <= load_i;
    end else if (shift_en_i) begin
      entry_q <= nbr_i;
    end
  end

  assign entry_o = entry_q;

endmodule

### hdl/hlt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlt_ctrl
// Sequencer: rotates the cell ring once per item, works on the head entry,
// keeps the counters and the result register.
// ----------------------------------------------------------------------------
module hlt_ctrl #(
  parameter int MAX_NODES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  hlt_cmd_if.sink                cmd_i,
  hlt_res_if.source              res_o,
  hlt_cfg_if.sink                cfg_i,
  input  hlt_pkg::entry_t        head_i,
  output hlt_pkg::entry_t        tail_o,
  output hlt_pkg::entry_t        new_o,
  output logic [MAX_NODES-1:0]   shift_en_o,
  output logic [MAX_NODES-1:0]   load_en_o
);

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  hlt_pkg::state_e state_q, state_d;
  hlt_pkg::cmd_e   cmd_q, cmd_d;
  logic [31:0]     key_q, key_d;
  logic [IW-1:0]   pos_q, pos_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [63:0]     beat_q, beat_d;
  logic [63:0]     mig_q, mig_d;
  logic [15:0]     limit_q;
  logic            found_q, found_d;
  logic [IW-1:0]   fidx_q, fidx_d;
  hlt_pkg::entry_t fent_q, fent_d;
  logic            out_valid_q;
  hlt_pkg::res_t   out_q, res_d;
  logic            emit;
  logic            out_free;

  logic [CW-1:0]   pos_ext;
  logic            head_used;
  logic            head_match;
  logic [15:0]     missed_inc;
  hlt_pkg::entry_t proc;

  assign out_free = !out_valid_q || res_o.ready;
  assign pos_ext  = CW'(pos_q);

  // Work on the head entry
  always_comb begin
    head_used  = pos_ext < cnt_q;
    head_match = head_used && (head_i.id == key_q);
    missed_inc = (head_i.missed == hlt_pkg::MISSED_MAX) ? head_i.missed
                                                        : head_i.missed + 16'd1;
    proc = head_i;
    if (cmd_q == hlt_pkg::CMD_ACK && head_match) begin
      proc.missed = '0;
      proc.alive  = 1'b1;
    end else if (cmd_q == hlt_pkg::CMD_TICK && head_used) begin
      proc.missed = missed_inc;
      proc.alive  = head_i.alive & ~(missed_inc >= limit_q);
    end
  end

  assign tail_o = proc;

  // Next state, cell enables and result selection
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    beat_d     = beat_q;
    mig_d      = mig_q;
    found_d    = found_q;
    fidx_d     = fidx_q;
    fent_d     = fent_q;
    emit       = 1'b0;
    res_d      = '0;
    shift_en_o = '0;
    load_en_o  = '0;
    new_o.id     = key_q;
    new_o.missed = '0;
    new_o.alive  = 1'b1;
    res_d.beats_total      = beat_q;
    res_d.migrations_total = mig_q;
    res_d.is_last          = 1'b1;
    res_d.status           = hlt_pkg::ST_OK;

    case (state_q)
      hlt_pkg::S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d   = hlt_pkg::cmd_e'(cmd_i.cmd);
          key_d   = cmd_i.node_id;
          found_d = 1'b0;
          pos_d   = '0;
          state_d = hlt_pkg::S_SCAN;
        end
      end

      hlt_pkg::S_SCAN: begin
        if (out_free) begin
          // rotate the ring one place
          shift_en_o = '1;
          if (head_match) begin
            found_d = 1'b1;
            fidx_d  = pos_q;
            fent_d  = (cmd_q == hlt_pkg::CMD_ACK) ? proc : head_i;
          end
          if (cmd_q == hlt_pkg::CMD_TICK && head_used) begin
            beat_d                 = beat_q + 64'd1;
            emit                   = 1'b1;
            res_d.entry_valid      = 1'b1;
            res_d.entry_node       = proc.id;
            res_d.entry_alive      = proc.alive;
            res_d.entry_missed     = proc.missed;
            res_d.entry_index      = 4'(pos_q);
            res_d.is_last          = ({1'b0, pos_ext} + (CW+1)'(1)) == {1'b0, cnt_q};
            res_d.beats_total      = beat_q + 64'd1;
          end
          if (pos_q == IW'(MAX_NODES - 1)) begin
            state_d = hlt_pkg::S_DONE;
          end else begin
            pos_d = pos_q + IW'(1);
          end
        end
      end

      hlt_pkg::S_DONE: begin
        if (out_free) begin
          state_d = hlt_pkg::S_IDLE;
          emit    = 1'b1;
          case (cmd_q)
            hlt_pkg::CMD_ADD: begin
              if (found_q) begin
                res_d.status = hlt_pkg::ST_EXISTS;
              end else if (cnt_q == CW'(MAX_NODES)) begin
                res_d.status = hlt_pkg::ST_FULL;
              end else begin
                for (int i = 0; i < MAX_NODES; i++) begin
                  load_en_o[i] = (CW'(i) == cnt_q);
                end
                cnt_d              = cnt_q + CW'(1);
                res_d.entry_valid  = 1'b1;
                res_d.entry_node   = key_q;
                res_d.entry_alive  = 1'b1;
                res_d.entry_missed = '0;
                res_d.entry_index  = 4'(cnt_q);
              end
            end
            hlt_pkg::CMD_REMOVE,
            hlt_pkg::CMD_ACK,
            hlt_pkg::CMD_MIGRATE: begin
              if (found_q) begin
                res_d.entry_valid  = 1'b1;
                res_d.entry_node   = fent_q.id;
                res_d.entry_alive  = fent_q.alive;
                res_d.entry_missed = fent_q.missed;
                res_d.entry_index  = 4'(fidx_q);
                if (cmd_q == hlt_pkg::CMD_REMOVE) begin
                  // close the gap: cells from the removed slot take their neighbor
                  for (int i = 0; i < MAX_NODES - 1; i++) begin
                    shift_en_o[i] = (IW'(i) >= fidx_q);
                  end
                  cnt_d = cnt_q - CW'(1);
                end
                if (cmd_q == hlt_pkg::CMD_MIGRATE) begin
                  mig_d                  = mig_q + 64'd1;
                  res_d.migrations_total = mig_q + 64'd1;
                end
              end else begin
                res_d.status = hlt_pkg::ST_NOT_FOUND;
              end
            end
            hlt_pkg::CMD_TICK: begin
              // a non-empty table already reported every entry
              emit = (cnt_q == '0);
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      default: begin
        state_d = hlt_pkg::S_IDLE;
      end
    endcase
  end

  assign cmd_i.ready = (state_q == hlt_pkg::S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hlt_pkg::S_IDLE;
      pos_q       <= '0;
      cnt_q       <= '0;
      beat_q      <= '0;
      mig_q       <= '0;
      found_q     <= 1'b0;
      limit_q     <= hlt_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      beat_q  <= beat_d;
      mig_q   <= mig_d;
      found_q <= found_d;
      if (cfg_i.valid) begin
        limit_q <= cfg_i.missed_limit;
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    fidx_q <= fidx_d;
    fent_q <= fent_d;
    if (emit) begin
      out_q <= res_d;
    end
  end

  // Drive the result channel from the output register
  assign res_o.valid            = out_valid_q;
  assign res_o.status           = out_q.status;
  assign res_o.entry_valid      = out_q.entry_valid;
  assign res_o.entry_node       = out_q.entry_node;
  assign res_o.entry_alive      = out_q.entry_alive;
  assign res_o.entry_missed     = out_q.entry_missed;
  assign res_o.entry_index      = out_q.entry_index;
  assign res_o.is_last          = out_q.is_last;
  assign res_o.beats_total      = out_q.beats_total;
  assign res_o.migrations_total = out_q.migrations_total;

endmodule

### hdl/heartbeat_liveness_table_core.sv
`timescale 1ns / 1ps
// Each item is accepted while idle, rotates the table once through its ring of cells
// and then finishes; no new item is accepted until it is done. A tick sends one result
// per used entry as the ring rotates; a waiting result stalls the ring. A tick on a
// non-empty table reports during the rotation, any other result in the finishing step.
// Reset clears the entry count, both totals and the control; the limit returns to 3.
// Table cells are not reset and are read only below the entry count.
// ----------------------------------------------------------------------------
// heartbeat_liveness_table_core
// Ordered peer table with missed-beat tracking, built as a ring of cells.
// ----------------------------------------------------------------------------
module heartbeat_liveness_table_core #(
  parameter int MAX_NODES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hlt_cmd_if.sink   cmd_i,
  hlt_res_if.source res_o,
  hlt_cfg_if.sink   cfg_i
);

  hlt_pkg::entry_t      cell_q [MAX_NODES];
  hlt_pkg::entry_t      tail;
  hlt_pkg::entry_t      new_entry;
  logic [MAX_NODES-1:0] shift_en;
  logic [MAX_NODES-1:0] load_en;

  // Sequencer
  hlt_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .res_o      (res_o),
    .cfg_i      (cfg_i),
    .head_i     (cell_q[0]),
    .tail_o     (tail),
    .new_o      (new_entry),
    .shift_en_o (shift_en),
    .load_en_o  (load_en)
  );

  // Ring of cells: each takes the next one, the last takes the worked head
  for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
    hlt_pkg::entry_t nbr;
    if (g == MAX_NODES - 1) begin : g_last
      assign nbr = tail;
    end else begin : g_mid
      assign nbr = cell_q[g+1];
    end
    hlt_cell u_cell (
      .clk_i      (clk_i),
      .shift_en_i (shift_en[g]),
      .load_en_i  (load_en[g]),
      .nbr_i      (nbr),
      .load_i     (new_entry),
      .entry_o    (cell_q[g])
    );
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the heartbeat liveness table. A queue-fed driver
// sends table commands, in some phases in random bursts, and a monitor
// compares every result item with a cycle-free software table that it keeps
// in step. The limit register is rewritten between phases. One phase ticks
// a single node alone under the highest limit.
// ----------------------------------------------------------------------------
module tb;

  localparam int          TABLE_DEPTH   = 16;
  localparam int          SETTLE_CYCLES = TABLE_DEPTH + 4;
  localparam int          DRAIN_LIMIT   = 2000000;
  localparam int          ERR_PRINT_MAX = 40;
  localparam int          SAT_TICKS     = 16;
  localparam logic [2:0]  OP_SPARE_LO   = 3'd5;
  localparam logic [2:0]  OP_SPARE_MID  = 3'd6;
  localparam logic [2:0]  OP_SPARE_HI   = 3'd7;
  localparam logic [31:0] SAT_NODE      = 32'h5A5A_0001;
  localparam int          POOL_SIZE     = 20;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] id;
  } cmd_item_t;

  logic clk;
  logic rst_n;

  hlt_cmd_if cmd_if ();
  hlt_res_if res_if ();
  hlt_cfg_if cfg_if ();

  heartbeat_liveness_table_core #(
    .MAX_NODES(TABLE_DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  // Shadow copy of the peer table
  logic [31:0] tab_id    [TABLE_DEPTH];
  logic [15:0] tab_miss  [TABLE_DEPTH];
  logic        tab_alive [TABLE_DEPTH];
  int          n_ent     = 0;
  logic [63:0] beat_sum  = '0;
  logic [63:0] mig_sum   = '0;
  logic [15:0] limit_now = hlt_pkg::LIMIT_RESET;

  cmd_item_t     cmd_backlog [$];
  hlt_pkg::res_t reports_due [$];
  logic [31:0]   id_pool [POOL_SIZE];

  // Driver and receiver controls
  bit          sender_bursty = 1'b0;
  bit          recv_stalls   = 1'b0;
  logic        cmd_taken     = 1'b0;
  int          burst_left    = 0;
  int          gap_left      = 0;
  cmd_item_t   next_item;
  logic [15:0] stall_pat     = '0;
  int          pat_age       = 0;

  int            err_cnt      = 0;
  int            items_sent   = 0;
  int            ticks_sent   = 0;
  int            results_seen = 0;
  int            limits_used  = 0;
  hlt_pkg::res_t want;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #150_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Table prediction
  // ---------------------------------------------------------------------------
  function automatic int find_node(logic [31:0] id);
    for (int i = 0; i < n_ent; i++) begin
      if (tab_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Queue one report on entry idx, or an empty report when idx is negative
  function automatic void add_report(hlt_pkg::status_e st, int idx, logic last);
    hlt_pkg::res_t r;
    r = '0;
    r.status = st;
    if (idx >= 0) begin
      r.entry_valid  = 1'b1;
      r.entry_node   = tab_id[idx];
      r.entry_alive  = tab_alive[idx];
      r.entry_missed = tab_miss[idx];
      r.entry_index  = idx[3:0];
    end
    r.is_last          = last;
    r.beats_total      = beat_sum;
    r.migrations_total = mig_sum;
    reports_due = {reports_due, r};
  endfunction

  function automatic void apply_cmd(logic [2:0] op, logic [31:0] id);
    int idx;
    idx = find_node(id);
    case (op)
      hlt_pkg::CMD_ADD: begin
        if (idx >= 0) begin
          add_report(hlt_pkg::ST_EXISTS, -1, 1'b1);
        end else if (n_ent >= TABLE_DEPTH) begin
          add_report(hlt_pkg::ST_FULL, -1, 1'b1);
        end else begin
          tab_id[n_ent]    = id;
          tab_miss[n_ent]  = '0;
          tab_alive[n_ent] = 1'b1;
          n_ent++;
          add_report(hlt_pkg::ST_OK, n_ent - 1, 1'b1);
        end
      end
      hlt_pkg::CMD_REMOVE: begin
        if (idx < 0) begin
          add_report(hlt_pkg::ST_NOT_FOUND, -1, 1'b1);
        end else begin
          add_report(hlt_pkg::ST_OK, idx, 1'b1);
          // close the gap, keep order
          for (int i = idx; i + 1 < n_ent; i++) begin
            tab_id[i]    = tab_id[i + 1];
            tab_miss[i]  = tab_miss[i + 1];
            tab_alive[i] = tab_alive[i + 1];
          end
          n_ent--;
        end
      end
      hlt_pkg::CMD_ACK: begin
        if (idx < 0) begin
          add_report(hlt_pkg::ST_NOT_FOUND, -1, 1'b1);
        end else begin
          tab_miss[idx]  = '0;
          tab_alive[idx] = 1'b1;
          add_report(hlt_pkg::ST_OK, idx, 1'b1);
        end
      end
      hlt_pkg::CMD_TICK: begin
        if (n_ent == 0) begin
          add_report(hlt_pkg::ST_OK, -1, 1'b1);
        end else begin
          for (int i = 0; i < n_ent; i++) begin
            beat_sum++;
            if (tab_miss[i] != hlt_pkg::MISSED_MAX) tab_miss[i]++;
            if (tab_miss[i] >= limit_now) tab_alive[i] = 1'b0;
            add_report(hlt_pkg::ST_OK, i, i == n_ent - 1);
          end
        end
      end
      hlt_pkg::CMD_MIGRATE: begin
        if (idx < 0) begin
          add_report(hlt_pkg::ST_NOT_FOUND, -1, 1'b1);
        end else begin
          mig_sum++;
          add_report(hlt_pkg::ST_OK, idx, 1'b1);
        end
      end
      default: begin
        add_report(hlt_pkg::ST_OK, -1, 1'b1);
      end
    endcase
  endfunction

  function automatic void check_field(string fname, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v) begin
      if (err_cnt < ERR_PRINT_MAX) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, exp_v, got_v);
      end
      err_cnt++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check result items, then advance the shadow table on commands
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_taken <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (reports_due.size() == 0) begin
          if (err_cnt < ERR_PRINT_MAX) begin
            $error("result item with none pending: node 0x%0h status %0d",
                   res_if.entry_node, res_if.status);
          end
          err_cnt++;
        end else begin
          want = reports_due.pop_front();
          check_field("status", want.status, res_if.status);
          check_field("entry_valid", want.entry_valid, res_if.entry_valid);
          check_field("entry_node", want.entry_node, res_if.entry_node);
          check_field("entry_alive", want.entry_alive, res_if.entry_alive);
          check_field("entry_missed", want.entry_missed, res_if.entry_missed);
          check_field("entry_index", want.entry_index, res_if.entry_index);
          check_field("is_last", want.is_last, res_if.is_last);
          check_field("beats_total", want.beats_total, res_if.beats_total);
          check_field("migrations_total", want.migrations_total, res_if.migrations_total);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        apply_cmd(cmd_if.cmd, cmd_if.node_id);
        items_sent++;
        if (cmd_if.cmd == hlt_pkg::CMD_TICK) ticks_sent++;
      end
      cmd_taken <= cmd_if.valid && cmd_if.ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: pop the backlog, when bursty in bursts separated by random gaps
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      cmd_if.valid   <= 1'b0;
      cmd_if.cmd     <= hlt_pkg::CMD_TICK;
      cmd_if.node_id <= '0;
    end else if (!cmd_if.valid || cmd_taken) begin
      if (gap_left > 0) begin
        cmd_if.valid <= 1'b0;
        gap_left     <= gap_left - 1;
      end else if (cmd_backlog.size() > 0) begin
        next_item = cmd_backlog.pop_front();
        cmd_if.valid   <= 1'b1;
        cmd_if.cmd     <= next_item.op;
        cmd_if.node_id <= next_item.id;
        if (sender_bursty) begin
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            gap_left   <= $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: while stalls are on, stall on a rotating pattern, reloaded with a random density
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n || !recv_stalls) begin
      res_if.ready <= 1'b1;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = '0;
          1:       stall_pat = 16'($urandom);
          default: stall_pat = 16'($urandom & $urandom);
        endcase
        pat_age = 48;
      end else begin
        stall_pat = {stall_pat[14:0], stall_pat[15]};
        pat_age--;
      end
      res_if.ready <= !stall_pat[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(logic [2:0] op, logic [31:0] id);
    cmd_item_t it;
    it.op = op;
    it.id = id;
    cmd_backlog = {cmd_backlog, it};
  endtask

  // Hold until the backlog is sent and every result item is back
  task automatic wait_drained();
    int waited;
    waited = 0;
    while ((cmd_backlog.size() != 0 || cmd_if.valid || reports_due.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) begin
      $error("%0d result items never arrived", reports_due.size());
      err_cnt++;
      reports_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] val);
    @(negedge clk);
    cfg_if.valid        <= 1'b1;
    cfg_if.missed_limit <= val;
    do @(posedge clk); while (!cfg_if.ready);
    limit_now = val;
    limits_used++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_id();
    if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Random command mix; add_w sets the share of adds in percent
  task automatic gen_random(int count, int add_w);
    int r;
    for (int k = 0; k < count; k++) begin
      // now and then let every pending command and result drain mid-stream
      if ($urandom_range(0, 39) == 0) wait_drained();
      r = $urandom_range(0, 99);
      if (r < add_w) begin
        queue_item(hlt_pkg::CMD_ADD, pick_id());
      end else begin
        r = $urandom_range(0, 19);
        if (r < 5)       queue_item(hlt_pkg::CMD_REMOVE, pick_id());
        else if (r < 9)  queue_item(hlt_pkg::CMD_ACK, pick_id());
        else if (r < 14) queue_item(hlt_pkg::CMD_TICK, $urandom);
        else if (r < 18) queue_item(hlt_pkg::CMD_MIGRATE, pick_id());
        else             queue_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] live_ids [$];

    cfg_if.valid        = 1'b0;
    cfg_if.missed_limit = hlt_pkg::LIMIT_RESET;
    rst_n               = 1'b0;

    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, misses, spare codes, duplicates, death, compaction
    queue_item(hlt_pkg::CMD_TICK, 32'h0);
    queue_item(hlt_pkg::CMD_REMOVE, 32'h0);
    queue_item(hlt_pkg::CMD_ACK, 32'hFFFF_FFFF);
    queue_item(hlt_pkg::CMD_MIGRATE, 32'h5);
    queue_item(OP_SPARE_LO, $urandom);
    queue_item(OP_SPARE_MID, $urandom);
    queue_item(OP_SPARE_HI, $urandom);
    queue_item(hlt_pkg::CMD_ADD, 32'h0000_0000);
    queue_item(hlt_pkg::CMD_ADD, 32'hFFFF_FFFF);
    queue_item(hlt_pkg::CMD_ADD, 32'h8000_0000);
    queue_item(hlt_pkg::CMD_ADD, 32'h0000_0000);
    queue_item(hlt_pkg::CMD_TICK, 32'h0);
    queue_item(hlt_pkg::CMD_TICK, 32'h0);
    queue_item(hlt_pkg::CMD_TICK, 32'h0);
    queue_item(hlt_pkg::CMD_ACK, 32'hFFFF_FFFF);
    queue_item(hlt_pkg::CMD_MIGRATE, 32'h0000_0000);
    queue_item(hlt_pkg::CMD_REMOVE, 32'hFFFF_FFFF);
    queue_item(hlt_pkg::CMD_TICK, 32'h0);
    wait_drained();

    // Limit of one, fill toward a full table under idling
    write_limit(16'd1);
    sender_bursty = 1'b1;
    recv_stalls   = 1'b1;
    gen_random(80, 45);
    wait_drained();

    // Zero limit: every beat kills
    write_limit(16'd0);
    gen_random(40, 25);
    wait_drained();

    // Mid limit, remove-heavy
    write_limit(16'($urandom_range(2, 6)));
    gen_random(90, 15);
    wait_drained();

    // Highest limit: one node alone, no idling
    write_limit(16'hFFFF);
    sender_bursty = 1'b0;
    recv_stalls   = 1'b0;
    for (int i = 0; i < n_ent; i++) live_ids = {live_ids, tab_id[i]};
    foreach (live_ids[i]) queue_item(hlt_pkg::CMD_REMOVE, live_ids[i]);
    queue_item(hlt_pkg::CMD_ADD, SAT_NODE);
    for (int i = 0; i < SAT_TICKS; i++) queue_item(hlt_pkg::CMD_TICK, $urandom);
    queue_item(hlt_pkg::CMD_MIGRATE, SAT_NODE);
    queue_item(hlt_pkg::CMD_ACK, SAT_NODE);
    queue_item(hlt_pkg::CMD_TICK, 32'h0);
    wait_drained();

    // Back to the reset limit: a plain stretch, then idling again
    write_limit(hlt_pkg::LIMIT_RESET);
    gen_random(30, 35);
    wait_drained();
    sender_bursty = 1'b1;
    recv_stalls   = 1'b1;
    gen_random(60, 30);
    wait_drained();

    $display("Run covered %0d commands (%0d ticks) and %0d result items", items_sent,
             ticks_sent, results_seen);
    $display("under %0d limit settings, with one node ticked alone at the highest limit",
             limits_used + 1);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
hdl/hlt_pkg.sv
hdl/hlt_cmd_if.sv
hdl/hlt_res_if.sv
hdl/hlt_cfg_if.sv
hdl/hlt_cell.sv
hdl/hlt_ctrl.sv
hdl/heartbeat_liveness_table_core.sv
tb/tb.sv
